// ===== hw/rtl/ntpf_pkg.sv =====
// Shared types, constants and helper functions for the number text parse and format core.
`timescale 1ns / 1ps
package ntpf_pkg;

	localparam int WORD_BITS  = 32;
	localparam int BCD_DIGITS = 10;
	localparam int BCD_BITS   = 4 * BCD_DIGITS;

	localparam logic [1:0] FMT_BIN  = 2'd0;
	localparam logic [1:0] FMT_SDEC = 2'd1;
	localparam logic [1:0] FMT_HEX  = 2'd2;
	localparam logic [1:0] FMT_SWAP = 2'd3;

	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_MINUS   = 8'h2d;
	localparam logic [7:0] CH_LOWER_B = 8'h62;
	localparam logic [7:0] CH_LOWER_X = 8'h78;
	localparam logic [7:0] CH_NL      = 8'h0a;
	localparam logic [7:0] HEX_ALPHA_OFS = 8'd87;

	localparam logic [1:0] POS_SAT = 2'd2;

	typedef struct packed {
		logic [7:0] in_char;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0]                   out_char;
		logic                         out_last;
		logic signed [WORD_BITS-1:0] parsed_value;
	} result_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CH_ZERO + {4'b0, d};
		end else begin
			c = HEX_ALPHA_OFS + {4'b0, d};
		end
		return c;
	endfunction

	function automatic logic [WORD_BITS-1:0] byte_swap(input logic [WORD_BITS-1:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

// ===== hw/rtl/ntpf_parse.sv =====
// Character parser: running decimal and hex accumulators and the sign-extended parse result.
`timescale 1ns / 1ps
module ntpf_parse #(
	parameter int VALUE_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  ntpf_pkg::in_item_t                item,
	output logic [ntpf_pkg::WORD_BITS-1:0]   value
);
	import ntpf_pkg::*;

	logic [VALUE_BITS-1:0] dec_q, hex_q, dec_d, hex_d, digit, hdig, dec_x10;
	logic signed [VALUE_BITS-1:0] sel;
	logic [1:0] pos_q, pos_d;
	logic       neg_q, hexf_q, neg_d, hexf_d, first_minus;

	always_comb begin
		digit       = VALUE_BITS'(item.in_char) - VALUE_BITS'(CH_ZERO);
		hdig        = (item.in_char <= CH_NINE) ? digit :
			VALUE_BITS'(item.in_char) - VALUE_BITS'(HEX_ALPHA_OFS);
		dec_x10     = (dec_q << 3) + (dec_q << 1);
		first_minus = (pos_q == 2'd0) && (item.in_char == CH_MINUS);
		if (first_minus) begin
			dec_d = dec_q;
		end else if (neg_q) begin
			dec_d = dec_x10 - digit;
		end else begin
			dec_d = dec_x10 + digit;
		end
		neg_d  = neg_q | first_minus;
		hexf_d = hexf_q | ((pos_q == 2'd1) && (item.in_char == CH_LOWER_X));
		hex_d  = (pos_q == POS_SAT) ? (hex_q << 4) + hdig : hex_q;
		pos_d  = (pos_q == POS_SAT) ? POS_SAT : pos_q + 2'd1;
		sel    = hexf_d ? hex_d : dec_d;
		value  = WORD_BITS'(sel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q  <= '0;
			hex_q  <= '0;
			pos_q  <= '0;
			neg_q  <= 1'b0;
			hexf_q <= 1'b0;
		end else if (accept) begin
			if (item.in_last) begin
				dec_q  <= '0;
				hex_q  <= '0;
				pos_q  <= '0;
				neg_q  <= 1'b0;
				hexf_q <= 1'b0;
			end else begin
				dec_q  <= dec_d;
				hex_q  <= hex_d;
				pos_q  <= pos_d;
				neg_q  <= neg_d;
				hexf_q <= hexf_d;
			end
		end
	end

endmodule

// ===== hw/rtl/ntpf_dabble.sv =====
// Iterative binary to BCD converter: one shift-and-add-three step per cycle.
`timescale 1ns / 1ps
module ntpf_dabble (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [ntpf_pkg::WORD_BITS-1:0]   operand,
	output logic                              done,
	output logic [ntpf_pkg::BCD_BITS-1:0]    bcd
);
	import ntpf_pkg::*;

	localparam int CNT_BITS = $clog2(WORD_BITS);
	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

	logic [WORD_BITS-1:0] bin_q;
	logic [BCD_BITS-1:0]  bcd_q, adj;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 run_q, done_q;

	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3 :
				bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q  <= '0;
			bcd_q  <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			bin_q  <= operand;
			bcd_q  <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			bcd_q <= {adj[BCD_BITS-2:0], bin_q[WORD_BITS-1]};
			bin_q <= bin_q << 1;
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_LAST) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

// ===== hw/rtl/ntpf_emit.sv =====
// Output sequencer: prefix, sign, digit shift register and newline of one text line.
`timescale 1ns / 1ps
module ntpf_emit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  logic [1:0]                        fmt,
	input  logic [ntpf_pkg::WORD_BITS-1:0]   value,
	output logic                              busy,
	output logic                              strobe,
	output ntpf_pkg::result_t                 result
);
	import ntpf_pkg::*;

	localparam logic [4:0] BIN_LAST = 5'(WORD_BITS - 1);
	localparam logic [4:0] HEX_LAST = 5'(WORD_BITS / 4 - 1);
	localparam logic [4:0] DEC_LAST = 5'(BCD_DIGITS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PFX0,
		ST_PFX1,
		ST_SIGN,
		ST_WAIT,
		ST_DIGITS,
		ST_NL
	} state_t;

	state_t               state_q;
	logic [1:0]           fmt_q;
	logic [WORD_BITS-1:0] work_q;
	logic [BCD_BITS-1:0]  shv_q;
	logic [4:0]           cnt_q;
	logic                 started_q, strobe_q, last_q;
	logic [7:0]           char_q;

	logic                 dab_start, dab_done, show;
	logic [WORD_BITS-1:0] dab_operand;
	logic [BCD_BITS-1:0]  dab_bcd;
	logic [3:0]           dig;

	always_comb begin
		dab_start   = load && (state_q == ST_IDLE) && ((fmt == FMT_SDEC) || (fmt == FMT_SWAP));
		dab_operand = (fmt == FMT_SDEC) ? (value[WORD_BITS-1] ? -value : value) :
			byte_swap(value);
		dig  = (fmt_q == FMT_BIN) ? {3'b0, shv_q[BCD_BITS-1]} : shv_q[BCD_BITS-1 -: 4];
		show = (dig != 4'd0) || started_q || (cnt_q == 5'd0);
	end

	ntpf_dabble u_dabble (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (dab_start),
		.operand (dab_operand),
		.done    (dab_done),
		.bcd     (dab_bcd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fmt_q     <= FMT_BIN;
			work_q    <= '0;
			shv_q     <= '0;
			cnt_q     <= '0;
			started_q <= 1'b0;
			strobe_q  <= 1'b0;
			last_q    <= 1'b0;
			char_q    <= '0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (load) begin
						fmt_q     <= fmt;
						work_q    <= value;
						shv_q     <= {value, (BCD_BITS - WORD_BITS)'(0)};
						started_q <= 1'b0;
						cnt_q     <= (fmt == FMT_BIN) ? BIN_LAST : HEX_LAST;
						case (fmt)
							FMT_BIN, FMT_HEX: state_q <= ST_PFX0;
							FMT_SDEC: state_q <= value[WORD_BITS-1] ? ST_SIGN : ST_WAIT;
							default: state_q <= ST_WAIT;
						endcase
					end
				end
				ST_PFX0: begin
					strobe_q <= 1'b1;
					char_q   <= CH_ZERO;
					state_q  <= ST_PFX1;
				end
				ST_PFX1: begin
					strobe_q <= 1'b1;
					char_q   <= (fmt_q == FMT_BIN) ? CH_LOWER_B : CH_LOWER_X;
					state_q  <= ST_DIGITS;
				end
				ST_SIGN: begin
					strobe_q <= 1'b1;
					char_q   <= CH_MINUS;
					state_q  <= ST_WAIT;
				end
				ST_WAIT: begin
					if (dab_done) begin
						shv_q   <= dab_bcd;
						cnt_q   <= DEC_LAST;
						state_q <= ST_DIGITS;
					end
				end
				ST_DIGITS: begin
					if (show) begin
						strobe_q  <= 1'b1;
						char_q    <= digit_char(dig);
						started_q <= 1'b1;
					end
					shv_q <= (fmt_q == FMT_BIN) ? shv_q << 1 : shv_q << 4;
					if (cnt_q == 5'd0) begin
						state_q <= ST_NL;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				ST_NL: begin
					strobe_q <= 1'b1;
					last_q   <= 1'b1;
					char_q   <= CH_NL;
					state_q  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy                = (state_q != ST_IDLE);
	assign strobe              = strobe_q;
	assign result.out_char     = char_q;
	assign result.out_last     = last_q;
	assign result.parsed_value = work_q;

	a_last_has_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last_q |-> strobe_q) else $error("line end without strobe");

	a_strobe_from_active: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> $past(state_q != ST_IDLE)) else $error("strobe while idle");

	a_end_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && last_q) |-> (state_q == ST_IDLE)) else $error("not idle after line end");

	a_wait_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT) |=> !strobe_q) else $error("strobe out of conversion wait");

endmodule

// ===== hw/rtl/number_text_parse_and_format_core.sv =====
// Top level of the number text parse and format core.
`timescale 1ns / 1ps
// Usage:
//   Input: one character per transfer on item, taken at a clock edge with start high
//   and busy low. item.in_last marks the final character of a number.
//   Non-final characters are taken while busy stays low.
//   The final character starts rendering of one text line; busy stays high until
//   the cycle that presents the closing newline, where it drops again.
//   Output: each character appears on result for one cycle with strobe high;
//   result.out_last marks the newline, result.parsed_value holds the parsed number.
//   The receiver cannot stall; characters are never held back.
//   Decimal and byte-swapped decimal lines wait for the 32 shift steps of the
//   binary to BCD unit; every digit position, emitted or skipped, passes through
//   the digit state once.
//   cfg_wr_en/cfg_wr_data write the output format (0 binary, 1 signed decimal,
//   2 hex, 3 byte-swapped unsigned decimal); write it only while idle.
//   Reset clears the parse state, the sequencer and the format to binary.
module number_text_parse_and_format_core #(
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  ntpf_pkg::in_item_t    item,
	output logic                  strobe,
	output ntpf_pkg::result_t     result,
	input  logic                  cfg_wr_en,
	input  logic [1:0]            cfg_wr_data
);
	import ntpf_pkg::*;

	logic                 accept, load;
	logic [1:0]           fmt_q;
	logic [WORD_BITS-1:0] value;

	assign accept = start && !busy;
	assign load   = accept && item.in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_BIN;
		end else if (cfg_wr_en) begin
			fmt_q <= cfg_wr_data;
		end
	end

	ntpf_parse #(
		.VALUE_BITS (VALUE_BITS)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.value  (value)
	);

	ntpf_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.fmt    (fmt_q),
		.value  (value),
		.busy   (busy),
		.strobe (strobe),
		.result (result)
	);

endmodule

// ===== bench/tb_number_text_parse_and_format_core.sv =====
// Self-checking bench for the number text parse and format core in all four line formats.
`timescale 1ns / 1ps
module tb_number_text_parse_and_format_core;
	import ntpf_pkg::*;

	localparam int WATCHDOG_CYCLES = 1500;
	localparam int RANDOM_ITEMS    = 100;
	localparam int NOISE_ITEMS     = 30;
	localparam int SETTLE_CYCLES   = 60;
	localparam int MAX_REPORTS     = 10;

	typedef logic [7:0] text_t[$];

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	in_item_t   item;
	logic       strobe;
	result_t    result;
	logic       cfg_wr_en;
	logic [1:0] cfg_wr_data;

	number_text_parse_and_format_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.strobe(strobe),
		.result(result),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	logic [1:0]  line_format = FMT_BIN;
	logic [31:0] dec_sum     = '0;
	logic [31:0] hex_sum     = '0;
	logic [1:0]  char_pos    = '0;
	logic        minus_seen  = 1'b0;
	logic        hex_seen    = 1'b0;
	result_t     expected_chars[$];

	int        chars_sent   = 0;
	int        lines_sent   = 0;
	int        chars_seen   = 0;
	int        mismatches   = 0;
	int        idle_cycles  = 0;
	bit        gaps_on      = 1'b1;
	bit [3:0]  formats_used = '0;

	function automatic void push_char(logic [7:0] c, logic l, logic [31:0] v);
		result_t r;
		r.out_char     = c;
		r.out_last     = l;
		r.parsed_value = v;
		expected_chars.push_back(r);
	endfunction

	function automatic void push_decimal(logic [31:0] u, logic [31:0] v);
		logic [3:0] digits [10];
		int n;
		n = 0;
		do begin
			digits[n] = 4'(u % 10);
			u = u / 10;
			n++;
		end while (u != 0 && n < 10);
		for (int i = n - 1; i >= 0; i--) begin
			push_char(CH_ZERO + {4'b0, digits[i]}, 1'b0, v);
		end
	endfunction

	function automatic void parse_char(logic [7:0] c, logic l);
		logic [31:0] d;
		logic [31:0] h;
		logic [31:0] v;
		logic [3:0]  nib;
		logic        started;
		d = {24'b0, c} - {24'b0, CH_ZERO};
		if (char_pos == 2'd0 && c == CH_MINUS) begin
			minus_seen = 1'b1;
		end else if (minus_seen) begin
			dec_sum = dec_sum * 10 - d;
		end else begin
			dec_sum = dec_sum * 10 + d;
		end
		if (char_pos == 2'd1 && c == CH_LOWER_X) begin
			hex_seen = 1'b1;
		end
		if (char_pos >= POS_SAT) begin
			h = (c <= CH_NINE) ? d : {24'b0, c} - {24'b0, HEX_ALPHA_OFS};
			hex_sum = hex_sum * 16 + h;
		end
		if (char_pos < POS_SAT) begin
			char_pos++;
		end
		if (!l) begin
			return;
		end

		v = hex_seen ? hex_sum : dec_sum;
		dec_sum    = '0;
		hex_sum    = '0;
		char_pos   = '0;
		minus_seen = 1'b0;
		hex_seen   = 1'b0;
		lines_sent++;
		formats_used[line_format] = 1'b1;

		case (line_format)
			FMT_BIN: begin
				push_char(CH_ZERO, 1'b0, v);
				push_char(CH_LOWER_B, 1'b0, v);
				started = 1'b0;
				for (int i = 31; i >= 0; i--) begin
					if (v[i] || started || i == 0) begin
						started = 1'b1;
						push_char(CH_ZERO + {7'b0, v[i]}, 1'b0, v);
					end
				end
			end
			FMT_SDEC: begin
				if (v[31]) begin
					push_char(CH_MINUS, 1'b0, v);
					push_decimal(-v, v);
				end else begin
					push_decimal(v, v);
				end
			end
			FMT_HEX: begin
				push_char(CH_ZERO, 1'b0, v);
				push_char(CH_LOWER_X, 1'b0, v);
				started = 1'b0;
				for (int i = 28; i >= 0; i -= 4) begin
					nib = v[i +: 4];
					if (nib != 0 || started || i == 0) begin
						started = 1'b1;
						push_char((nib < 4'd10) ? CH_ZERO + {4'b0, nib}
							: HEX_ALPHA_OFS + {4'b0, nib}, 1'b0, v);
					end
				end
			end
			default: begin
				push_decimal({v[7:0], v[15:8], v[23:16], v[31:24]}, v);
			end
		endcase
		push_char(CH_NL, 1'b1, v);
	endfunction

	function automatic text_t text_of(string s);
		text_t t;
		foreach (s[i]) begin
			t.push_back(s[i]);
		end
		return t;
	endfunction

	function automatic int pick_gap();
		int r;
		if (!gaps_on) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end
		if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	task automatic send_char(logic [7:0] c, logic l);
		int gap;
		@(negedge clk);
		start        = 1'b1;
		item.in_char = c;
		item.in_last = l;
		do @(posedge clk); while (busy);
		parse_char(c, l);
		chars_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_line(text_t t);
		foreach (t[i]) begin
			send_char(t[i], i == t.size() - 1);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (expected_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_format(logic [1:0] f);
		drain();
		@(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = f;
		@(negedge clk);
		cfg_wr_en   = 1'b0;
		line_format = f;
	endtask

	task automatic build_number(output text_t t);
		logic [31:0] v;
		int n;
		v = $urandom;
		case ($urandom_range(0, 9))
			0, 1: t = text_of($sformatf("%0d", $urandom_range(0, 999)));
			2: t = text_of($sformatf("%0d", $signed(v)));
			3: t = text_of($sformatf("-%0d", $urandom_range(0, 99)));
			4, 5: t = text_of($sformatf("0x%0h", v >> $urandom_range(0, 31)));
			6: t = text_of($sformatf("0x%h", v));
			7: t = text_of($sformatf("%0d", v));
			8: begin
				t = text_of($urandom_range(0, 1) ? "0x" : "-x");
				n = $urandom_range(1, 8);
				repeat (n) t.push_back(8'($urandom_range(8'h30, 8'h7a)));
			end
			default: t = text_of($sformatf("%0d", $urandom_range(0, 9)));
		endcase
	endtask

	task automatic test_directed_values();
		write_format(FMT_BIN);
		send_line(text_of("0"));
		send_line(text_of("-1"));
		send_line(text_of("5"));
		write_format(FMT_SDEC);
		send_line(text_of("-2147483648"));
		send_line(text_of("-"));
		write_format(FMT_HEX);
		send_line(text_of("0x0"));
		send_line(text_of("0xff"));
		write_format(FMT_SWAP);
		send_line(text_of("0"));
		send_line(text_of("256"));
	endtask

	task automatic test_random_lines();
		logic [1:0] fmt_cycle [4];
		text_t t;
		int target;
		int seg;
		fmt_cycle = '{FMT_SWAP, FMT_HEX, FMT_SDEC, FMT_BIN};
		target = chars_sent + RANDOM_ITEMS;
		seg = 0;
		while (chars_sent < target) begin
			write_format(fmt_cycle[seg % 4]);
			gaps_on = (seg % 3 != 2);
			repeat (4) begin
				build_number(t);
				send_line(t);
			end
			seg++;
		end
		gaps_on = 1'b1;
	endtask

	task automatic test_noise_bytes();
		logic [1:0] fmt_cycle [4];
		text_t t;
		int target;
		int seg;
		fmt_cycle = '{FMT_HEX, FMT_BIN, FMT_SWAP, FMT_SDEC};
		target = chars_sent + NOISE_ITEMS;
		seg = 0;
		while (chars_sent < target) begin
			write_format(fmt_cycle[seg % 4]);
			t = {};
			repeat ($urandom_range(1, 4)) t.push_back(8'($urandom));
			send_line(t);
			seg++;
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && strobe) begin
			chars_seen++;
			if (expected_chars.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("unexpected char %h last %b value %h", result.out_char,
						result.out_last, result.parsed_value);
				end
			end else begin
				want = expected_chars.pop_front();
				if (result.out_char !== want.out_char || result.out_last !== want.out_last
					|| result.parsed_value !== want.parsed_value) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("mismatch: char %h/%h last %b/%b value %h/%h (exp/act)",
							want.out_char, result.out_char, want.out_last, result.out_last,
							want.parsed_value, result.parsed_value);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("watchdog: no transfer for %0d cycles", idle_cycles);
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		item        = '0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = FMT_BIN;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_values();
		test_random_lines();
		test_noise_bytes();
		drain();

		$display("Sent %0d characters in %0d lines; checked %0d output characters.",
			chars_sent, lines_sent, chars_seen);
		$display("Formats exercised %b; %0d mismatches.", formats_used, mismatches);
		if (mismatches == 0 && expected_chars.size() == 0) begin
			$display("PASS");
		end else begin
			$display("%0d expected characters never arrived", expected_chars.size());
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/ntpf_pkg.sv
hw/rtl/ntpf_parse.sv
hw/rtl/ntpf_dabble.sv
hw/rtl/ntpf_emit.sv
hw/rtl/number_text_parse_and_format_core.sv
bench/tb_number_text_parse_and_format_core.sv
